// ===== src/assert_macros.svh =====
// assertion helpers included by the rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SCSPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a check in the next cycle
`define SCSPE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/scspe_pkg.sv =====
package scspe_pkg;

  // fixed field widths
  localparam int unsigned JerkW      = 31;
  localparam int unsigned CountW     = 24;
  localparam int unsigned CruiseW    = 31;
  localparam int unsigned StepsW     = 31;
  localparam int unsigned InDataW    = 112;
  localparam int unsigned OutDataW   = 104;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned FracW      = 9;
  localparam int unsigned PositionFractionBits = 24;

  // register map, index as seen on paddr above the byte offset
  localparam logic [0:0] REG_JERK = 1'b0;
  localparam logic [JerkW-1:0] JERK_RESET = 31'd67;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_JERK_UP   = 3'd1,
    PH_ACCEL     = 3'd2,
    PH_JERK_FLAT = 3'd3,
    PH_CRUISE    = 3'd4,
    PH_JERK_IN   = 3'd5,
    PH_DECEL     = 3'd6,
    PH_JERK_OUT  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    MO_IDLE   = 2'd0,
    MO_ACCEL  = 2'd1,
    MO_CRUISE = 2'd2,
    MO_DECEL  = 2'd3
  } motion_e;

  // first phase after cur whose sample count is non-zero, idle when none is left
  function automatic phase_e next_phase(phase_e cur, logic j_nz, logic c_nz, logic cr_nz);
    phase_e nx;
    phase_e cand;
    logic   nz;
    nx = PH_IDLE;
    for (int i = 7; i >= 1; i--) begin
      cand = phase_e'(3'(i));
      case (cand) inside
        PH_ACCEL, PH_DECEL: nz = c_nz;
        PH_CRUISE:          nz = cr_nz;
        default:            nz = j_nz;
      endcase
      if (nz && (cand > cur)) begin
        nx = cand;
      end
    end
    return nx;
  endfunction

endpackage

// ===== src/scurve_step_profile_executor.sv =====
// channel  | dir | handshake                | payload
// s_axis   | in  | tvalid / tready          | tuser: operation; tdata: move fields
// m_axis   | out | tvalid / tready          | tdata: steps, direction, position, status
// apb      | in  | psel / penable / pready  | jerk_per_sample at byte address 0
//
// The sample update runs between the input and the result register, and a new
// item is taken each cycle while the result register is empty or being drained.
// The result is registered and appears in the cycle after the item is accepted.
// A stalled output holds its item and blocks input only while it is full and not taken.
// Asynchronous active-low reset clears the motion state, jerk register resets to 67.
`include "assert_macros.svh"

module scurve_step_profile_executor import scspe_pkg::*; #(
  parameter int unsigned POSITION_FRACTION_BITS = PositionFractionBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // target[31:0], absolute[32], jerk_samples[56:33], const_accel_samples[80:57],
  // cruise_samples[111:81]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // operation[0]
  input  logic                s_axis_tuser_i,
  // result items
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // steps[30:0], reverse[31], position[63:32], phase[66:64], motion_state[68:67],
  // correction[99:69], zero pad[103:100]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  // input field split
  op_e                in_op;
  logic [31:0]        in_target;
  logic               in_absolute;
  logic [CountW-1:0]  in_jerk_cnt;
  logic [CountW-1:0]  in_const_cnt;
  logic [CruiseW-1:0] in_cruise_cnt;
  logic               in_acc;

  assign in_op         = op_e'(s_axis_tuser_i);
  assign in_target     = s_axis_tdata_i[31:0];
  assign in_absolute   = s_axis_tdata_i[32];
  assign in_jerk_cnt   = s_axis_tdata_i[56:33];
  assign in_const_cnt  = s_axis_tdata_i[80:57];
  assign in_cruise_cnt = s_axis_tdata_i[111:81];

  // state
  logic [JerkW-1:0]   cfg_jerk_q;
  logic [JerkW-1:0]   jerk_lat_q, jerk_lat_d;
  phase_e             phase_q, phase_d;
  logic [CruiseW-1:0] left_q, left_d;
  logic [CountW-1:0]  cnt_jerk_q, cnt_jerk_d;
  logic [CountW-1:0]  cnt_const_q, cnt_const_d;
  logic [CruiseW-1:0] cnt_cruise_q, cnt_cruise_d;
  logic [FracW-1:0]   frac_q, frac_d;
  logic [31:0]        accel_q, accel_d;
  logic [63:0]        vel_q, vel_d;
  logic [63:0]        pos_fine_q, pos_fine_d;
  logic [31:0]        sent_q, sent_d;
  logic [31:0]        move_len_q, move_len_d;
  logic               going_rev_q, going_rev_d;
  logic [31:0]        abs_pos_q, abs_pos_d;
  logic [31:0]        corr_q, corr_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[ApbAddrW-1:2] == REG_JERK);
  assign prdata = (paddr[ApbAddrW-1:2] == REG_JERK) ? {1'b0, cfg_jerk_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_jerk_q <= JERK_RESET;
    end else if (cfg_wr) begin
      cfg_jerk_q <= pwdata[JerkW-1:0];
    end
  end

  // handshake
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // one sample of the profile integrators
  logic [31:0] jerk_term;
  logic [31:0] frac_sum;
  logic [31:0] accel_tick;
  logic [FracW-1:0] frac_tick;
  logic [63:0] vel_tick;
  logic [63:0] pos_tick;
  logic [31:0] cur_steps;
  logic [31:0] dsteps;

  always_comb begin
    case (phase_q) inside
      PH_JERK_UP, PH_JERK_OUT: jerk_term = {1'b0, jerk_lat_q};
      PH_JERK_FLAT, PH_JERK_IN: jerk_term = 32'd0 - {1'b0, jerk_lat_q};
      default: jerk_term = '0;
    endcase
  end

  assign frac_sum   = {{(32-FracW){1'b0}}, frac_q} + jerk_term;
  assign accel_tick = (phase_q == PH_CRUISE) ? '0
                    : accel_q + {{FracW{frac_sum[31]}}, frac_sum[31:FracW]};
  assign frac_tick  = (phase_q == PH_CRUISE) ? '0 : frac_sum[FracW-1:0];
  assign vel_tick   = vel_q + {{32{accel_tick[31]}}, accel_tick};
  assign pos_tick   = pos_fine_q + vel_tick;
  assign cur_steps  = pos_tick[POSITION_FRACTION_BITS+31:POSITION_FRACTION_BITS];
  assign dsteps     = cur_steps - sent_q;

  // start distance
  logic [31:0] start_dist;
  assign start_dist = in_absolute ? (in_target - abs_pos_q) : in_target;

  // next state and result fields
  logic               adv;
  phase_e             nx;
  logic [33:0]        rem;
  logic signed [35:0] net;
  logic [35:0]        net_mag;
  motion_e            motion;
  logic [StepsW-1:0]  out_steps;
  logic               out_rev;
  logic [StepsW-1:0]  out_corr;

  always_comb begin
    jerk_lat_d   = jerk_lat_q;
    phase_d      = phase_q;
    left_d       = left_q;
    cnt_jerk_d   = cnt_jerk_q;
    cnt_const_d  = cnt_const_q;
    cnt_cruise_d = cnt_cruise_q;
    frac_d       = frac_q;
    accel_d      = accel_q;
    vel_d        = vel_q;
    pos_fine_d   = pos_fine_q;
    sent_d       = sent_q;
    move_len_d   = move_len_q;
    going_rev_d  = going_rev_q;
    corr_d       = corr_q;
    adv          = 1'b0;
    nx           = PH_IDLE;
    rem          = '0;
    net          = '0;
    motion       = MO_IDLE;

    if (in_acc) begin
      if (in_op == OP_START) begin
        // new move, abandons any running one
        going_rev_d  = start_dist[31];
        move_len_d   = start_dist[31] ? (32'd0 - start_dist) : start_dist;
        jerk_lat_d   = (cfg_jerk_q == '0) ? JerkW'(1) : cfg_jerk_q;
        cnt_jerk_d   = in_jerk_cnt;
        cnt_const_d  = in_const_cnt;
        cnt_cruise_d = in_cruise_cnt;
        pos_fine_d   = '0;
        vel_d        = '0;
        accel_d      = '0;
        frac_d       = '0;
        sent_d       = '0;
        left_d       = '0;
        corr_d       = '0;
        phase_d      = PH_IDLE;
        motion       = MO_ACCEL;
        if (move_len_d != '0) begin
          phase_d = PH_JERK_UP;
          left_d  = {{(CruiseW-CountW){1'b0}}, in_jerk_cnt};
          adv     = (in_jerk_cnt == '0);
        end
      end else if (phase_q != PH_IDLE) begin
        // one sample tick
        frac_d     = frac_tick;
        accel_d    = accel_tick;
        vel_d      = vel_tick;
        pos_fine_d = pos_tick;
        sent_d     = cur_steps;
        net        = {{4{dsteps[31]}}, dsteps};
        if (phase_q <= PH_JERK_FLAT) begin
          motion = MO_ACCEL;
        end else if (phase_q == PH_CRUISE) begin
          motion = MO_CRUISE;
        end else begin
          motion = MO_DECEL;
        end
        if (left_q <= CruiseW'(1)) begin
          left_d = '0;
          adv    = 1'b1;
        end else begin
          left_d = left_q - CruiseW'(1);
        end
      end
    end

    // move to the next non-empty phase, or finish and flush missing steps
    if (adv) begin
      nx = next_phase(phase_d, cnt_jerk_d != '0, cnt_const_d != '0, cnt_cruise_d != '0);
      if (nx == PH_IDLE) begin
        rem = {2'b00, move_len_d} - {{2{sent_d[31]}}, sent_d};
        if (!rem[33] && (rem != '0)) begin
          net    = net + {{2{rem[33]}}, rem};
          sent_d = move_len_d;
          corr_d = rem[31:0];
        end
        phase_d = PH_IDLE;
        frac_d  = '0;
        accel_d = '0;
        vel_d   = '0;
      end else begin
        phase_d = nx;
        case (nx) inside
          PH_ACCEL, PH_DECEL: left_d = {{(CruiseW-CountW){1'b0}}, cnt_const_d};
          PH_CRUISE:          left_d = cnt_cruise_d;
          default:            left_d = {{(CruiseW-CountW){1'b0}}, cnt_jerk_d};
        endcase
      end
    end

    abs_pos_d = going_rev_d ? (abs_pos_q - net[31:0]) : (abs_pos_q + net[31:0]);

    if (phase_d == PH_IDLE) begin
      motion = MO_IDLE;
    end

    // direction and saturated magnitudes
    out_rev   = going_rev_d ^ net[35];
    net_mag   = net[35] ? (36'd0 - net) : net;
    out_steps = (net_mag > 36'h0_7FFF_FFFF) ? {StepsW{1'b1}} : net_mag[StepsW-1:0];
    out_corr  = corr_d[31] ? {StepsW{1'b1}} : corr_d[StepsW-1:0];
  end

  // result register valid
  always_comb begin
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jerk_lat_q   <= '0;
      phase_q      <= PH_IDLE;
      left_q       <= '0;
      cnt_jerk_q   <= '0;
      cnt_const_q  <= '0;
      cnt_cruise_q <= '0;
      frac_q       <= '0;
      accel_q      <= '0;
      vel_q        <= '0;
      pos_fine_q   <= '0;
      sent_q       <= '0;
      move_len_q   <= '0;
      going_rev_q  <= 1'b0;
      abs_pos_q    <= '0;
      corr_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      jerk_lat_q   <= jerk_lat_d;
      phase_q      <= phase_d;
      left_q       <= left_d;
      cnt_jerk_q   <= cnt_jerk_d;
      cnt_const_q  <= cnt_const_d;
      cnt_cruise_q <= cnt_cruise_d;
      frac_q       <= frac_d;
      accel_q      <= accel_d;
      vel_q        <= vel_d;
      pos_fine_q   <= pos_fine_d;
      sent_q       <= sent_d;
      move_len_q   <= move_len_d;
      going_rev_q  <= going_rev_d;
      abs_pos_q    <= abs_pos_d;
      corr_q       <= corr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= {4'b0000, out_corr, motion, phase_d, abs_pos_d, out_rev, out_steps};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // checks
  `SCSPE_ASSERT(a_idle_no_motion, !m_axis_tvalid_o || (m_axis_tdata_o[66:64] != PH_IDLE) || (m_axis_tdata_o[68:67] == MO_IDLE), "idle result reports motion")
  `SCSPE_ASSERT(a_phase_has_samples, (phase_q == PH_IDLE) || (left_q != '0), "active phase with no samples left")
  `SCSPE_ASSERT(a_idle_integrators_clear, (phase_q != PH_IDLE) || ((accel_q == '0) && (vel_q == '0) && (frac_q == '0)), "integrators not cleared when idle")
  `SCSPE_ASSERT_NEXT(a_idle_tick_holds, in_acc && (in_op == OP_TICK) && (phase_q == PH_IDLE), (phase_q == PH_IDLE) && (abs_pos_q == $past(abs_pos_q)), "idle tick changed the position")

endmodule

// ===== tb/sv/scurve_step_profile_executor_tb.sv =====
module scurve_step_profile_executor_tb;
  import scspe_pkg::*;

  localparam logic [30:0] StepsMax = '1;

  // one result item, laid out as on m_axis_tdata_o[99:0]
  typedef struct packed {
    logic [30:0] correction;
    motion_e     motion;
    phase_e      phase;
    logic [31:0] position;
    logic        reverse;
    logic [30:0] steps;
  } report_t;

  typedef struct {
    op_e         op;
    logic [31:0] target;
    logic        absol;
    logic [23:0] jerk_cnt;
    logic [23:0] const_cnt;
    logic [30:0] cruise_cnt;
    bit          known;
    report_t     want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  // target, absolute, jerk_samples, const_accel_samples, cruise_samples
  logic [InDataW-1:0]  s_axis_tdata_i;
  // operation
  logic                s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // steps, reverse, position, phase, motion_state, correction, zero pad
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  scurve_step_profile_executor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // tracked profile state, reset values
  logic [30:0] jerk_reg      = JERK_RESET;
  logic [31:0] trk_jerk      = '0;
  phase_e      trk_phase     = PH_IDLE;
  logic [31:0] trk_left      = '0;
  logic [31:0] trk_cnt_jerk  = '0;
  logic [31:0] trk_cnt_const = '0;
  logic [31:0] trk_cnt_cruise = '0;
  logic [31:0] trk_frac      = '0;
  logic [31:0] trk_accel     = '0;
  logic [63:0] trk_vel       = '0;
  logic [63:0] trk_pos_fine  = '0;
  logic [31:0] trk_sent      = '0;
  logic [31:0] trk_len       = '0;
  logic        trk_rev       = 1'b0;
  logic [31:0] trk_abs_pos   = '0;
  logic [31:0] trk_corr      = '0;
  longint      net_steps;

  report_t   step_reports_due[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        rx_count = 0;
  bit        tx_steady = 1'b0;

  // sample count of a phase
  function automatic logic [31:0] samples_of(int ph);
    if (ph == PH_ACCEL || ph == PH_DECEL) return trk_cnt_const;
    if (ph == PH_CRUISE) return trk_cnt_cruise;
    return trk_cnt_jerk;
  endfunction

  function automatic void shift_position(longint d);
    trk_abs_pos = trk_rev ? trk_abs_pos - d[31:0] : trk_abs_pos + d[31:0];
  endfunction

  // next non-empty phase, or end of move with flush of missing steps
  function automatic void step_to_next_phase();
    int                 nx;
    longint             rem;
    logic signed [31:0] sent_s;
    nx = int'(trk_phase) + 1;
    while (nx <= 7 && samples_of(nx) == 0) nx++;
    if (nx > 7) begin
      sent_s = trk_sent;
      rem = longint'({32'd0, trk_len}) - longint'(sent_s);
      if (rem > 0) begin
        net_steps += rem;
        shift_position(rem);
        trk_sent = trk_len;
        trk_corr = rem[31:0];
      end
      trk_phase = PH_IDLE;
      trk_frac  = '0;
      trk_accel = '0;
      trk_vel   = '0;
    end else begin
      trk_phase = phase_e'(nx[2:0]);
      trk_left  = samples_of(nx);
    end
  endfunction

  // advance the tracked profile by one item and build its report
  function automatic report_t advance_profile(op_e op, logic [InDataW-1:0] d);
    logic [31:0]        tgt;
    logic [31:0]        move_dist;
    logic [31:0]        jinc;
    logic [31:0]        cur;
    logic signed [31:0] s_sig;
    logic signed [31:0] diff;
    logic signed [63:0] pos_sh;
    longint             dsteps;
    longint             mag;
    phase_e             ph;
    motion_e            mo;
    logic               rev;
    report_t            r;
    net_steps = 0;
    mo = MO_IDLE;
    if (op == OP_START) begin
      tgt  = d[31:0];
      move_dist = d[32] ? tgt - trk_abs_pos : tgt;
      trk_rev = move_dist[31];
      trk_len = trk_rev ? 32'd0 - move_dist : move_dist;
      trk_jerk = (jerk_reg != '0) ? {1'b0, jerk_reg} : 32'd1;
      trk_cnt_jerk   = {8'd0, d[56:33]};
      trk_cnt_const  = {8'd0, d[80:57]};
      trk_cnt_cruise = {1'b0, d[111:81]};
      trk_pos_fine = '0;
      trk_vel   = '0;
      trk_accel = '0;
      trk_frac  = '0;
      trk_sent  = '0;
      trk_left  = '0;
      trk_corr  = '0;
      trk_phase = PH_IDLE;
      if (trk_len != '0) begin
        trk_phase = PH_JERK_UP;
        trk_left  = trk_cnt_jerk;
        if (trk_left == '0) step_to_next_phase();
      end
      mo = MO_ACCEL;
    end else if (trk_phase != PH_IDLE) begin
      ph = trk_phase;
      case (ph) inside
        PH_JERK_UP, PH_JERK_OUT:  jinc = trk_jerk;
        PH_JERK_FLAT, PH_JERK_IN: jinc = 32'd0 - trk_jerk;
        default:                  jinc = '0;
      endcase
      // jerk into the fraction, carry into acceleration
      s_sig = trk_frac + jinc;
      trk_accel = trk_accel + 32'(s_sig >>> 9);
      trk_frac  = {23'd0, s_sig[8:0]};
      if (ph == PH_CRUISE) begin
        trk_accel = '0;
        trk_frac  = '0;
      end
      trk_vel = trk_vel + {{32{trk_accel[31]}}, trk_accel};
      trk_pos_fine = trk_pos_fine + trk_vel;
      pos_sh = $signed(trk_pos_fine) >>> PositionFractionBits;
      cur = pos_sh[31:0];
      diff = cur - trk_sent;
      dsteps = diff;
      trk_sent = cur;
      shift_position(dsteps);
      net_steps += dsteps;
      mo = (ph <= PH_JERK_FLAT) ? MO_ACCEL : ((ph == PH_CRUISE) ? MO_CRUISE : MO_DECEL);
      if (trk_left <= 32'd1) begin
        trk_left = '0;
        step_to_next_phase();
      end else begin
        trk_left = trk_left - 32'd1;
      end
    end
    if (trk_phase == PH_IDLE) mo = MO_IDLE;
    // lost steps go the other way
    rev = trk_rev;
    if (net_steps < 0) begin
      rev = ~rev;
      mag = -net_steps;
    end else begin
      mag = net_steps;
    end
    if (mag > 2147483647) mag = 2147483647;
    r.steps      = mag[30:0];
    r.reverse    = rev;
    r.position   = trk_abs_pos;
    r.phase      = trk_phase;
    r.motion     = mo;
    r.correction = (trk_corr > 32'h7FFF_FFFF) ? StepsMax : trk_corr[30:0];
    return r;
  endfunction

  function automatic logic [InDataW-1:0] pack_move(logic [31:0] tgt, logic absol,
                                                   logic [23:0] js, logic [23:0] cs,
                                                   logic [30:0] cr);
    return {cr, cs, js, absol, tgt};
  endfunction

  function automatic logic [InDataW-1:0] noise_data();
    return InDataW'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  // idle report with the given step and position fields
  function automatic report_t idle_report(logic [30:0] steps, logic rev, logic [31:0] pos,
                                          logic [30:0] corr);
    report_t r;
    r.steps      = steps;
    r.reverse    = rev;
    r.position   = pos;
    r.phase      = PH_IDLE;
    r.motion     = MO_IDLE;
    r.correction = corr;
    return r;
  endfunction

  function automatic void add_row(op_e op, logic [31:0] tgt, logic absol, logic [23:0] js,
                                  logic [23:0] cs, logic [30:0] cr, bit known,
                                  report_t want);
    stim_row_t row;
    row.op         = op;
    row.target     = tgt;
    row.absol      = absol;
    row.jerk_cnt   = js;
    row.const_cnt  = cs;
    row.cruise_cnt = cr;
    row.known      = known;
    row.want       = want;
    directed_rows.push_back(row);
  endfunction

  // offer one item, called and returning at a falling edge
  task automatic send_item(op_e op, logic [InDataW-1:0] d, bit known, report_t want);
    int      gap;
    report_t r;
    if (items_sent % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= op;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = advance_profile(op, d);
    step_reports_due.push_back(known ? want : r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, noise_data(), 1'b0, '0);
  endtask

  // stop offering and let every pending result come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (step_reports_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [30:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_JERK, 2'b00};
    pwdata  <= {1'b0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    jerk_reg = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(output logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {REG_JERK, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    val = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_jerk(logic [30:0] val);
    logic [31:0] rd;
    cfg_write(val);
    cfg_read(rd);
    if (rd != {1'b0, val}) begin
      $error("jerk_per_sample: expected %0d, got %0d", val, rd);
      mismatches++;
    end
  endtask

  // one move: mostly complete profiles, some cut short or with random headers
  task automatic run_move();
    logic [31:0] tgt;
    logic        absol;
    logic [23:0] js;
    logic [23:0] cs;
    logic [30:0] cr;
    int          sel;
    int          stop_at;
    int          n;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      send_item(OP_START, noise_data(), 1'b0, '0);
      repeat ($urandom_range(1, 4)) send_tick();
    end else begin
      case (sel)
        1: begin
          tgt   = $urandom;
          absol = 1'($urandom_range(0, 1));
        end
        2, 3: begin
          tgt   = 32'($urandom_range(0, 400)) - 32'd200;
          absol = 1'b0;
        end
        4: begin
          tgt   = 32'($urandom_range(0, 20));
          absol = 1'($urandom_range(0, 1));
        end
        default: begin
          tgt   = trk_abs_pos + 32'($urandom_range(0, 600)) - 32'd300;
          absol = 1'b1;
        end
      endcase
      js = ($urandom_range(0, 4) == 0) ? 24'd0 : 24'($urandom_range(1, 6));
      cs = ($urandom_range(0, 3) == 0) ? 24'd0 : 24'($urandom_range(1, 6));
      cr = ($urandom_range(0, 3) == 0) ? 31'd0 : 31'($urandom_range(1, 10));
      send_item(OP_START, pack_move(tgt, absol, js, cs, cr), 1'b0, '0);
      stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : -1;
      n = 0;
      while (trk_phase != PH_IDLE && n != stop_at) begin
        send_tick();
        n++;
      end
      repeat ($urandom_range(0, 2)) send_tick();
    end
  endtask

  // result side: random stalls, one long hold-off to back up the input
  initial begin : result_sink
    int gap;
    bit steady;
    steady = 1'b0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_count % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = (rx_count == 60) ? 300 : (steady ? 0 : $urandom_range(0, 10));
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      rx_count++;
      @(negedge clk_i);
    end
  end

  // compare each result item with the oldest pending report
  always @(posedge clk_i) begin : report_check
    report_t got;
    report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = report_t'(m_axis_tdata_o[99:0]);
      if (step_reports_due.size() == 0) begin
        $error("result item with no expected item pending");
        mismatches++;
      end else begin
        want = step_reports_due.pop_front();
        if (got.steps != want.steps) begin
          $error("steps: expected %0d, got %0d", want.steps, got.steps);
          mismatches++;
        end
        if (got.reverse != want.reverse) begin
          $error("reverse: expected %0d, got %0d", want.reverse, got.reverse);
          mismatches++;
        end
        if (got.position != want.position) begin
          $error("position: expected %0d, got %0d", $signed(want.position),
                 $signed(got.position));
          mismatches++;
        end
        if (got.phase != want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, got.phase);
          mismatches++;
        end
        if (got.motion != want.motion) begin
          $error("motion_state: expected %0d, got %0d", want.motion, got.motion);
          mismatches++;
        end
        if (got.correction != want.correction) begin
          $error("correction: expected %0d, got %0d", want.correction, got.correction);
          mismatches++;
        end
      end
    end
  end

  // run limit
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    stim_row_t         row;
    logic [InDataW-1:0] d;
    logic [31:0]       rd;
    logic [30:0]       jerk_pick;
    int                base;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_TICK;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // tick straight after reset
    add_row(OP_TICK, 0, 0, 0, 0, 0, 1'b1, idle_report(0, 1'b0, 32'd0, 0));
    // absolute distance of exactly 2^31, every phase empty: all flushed, saturated
    add_row(OP_START, 32'h8000_0000, 1'b1, 0, 0, 0, 1'b1,
            idle_report(StepsMax, 1'b1, 32'h8000_0000, StepsMax));
    // idle tick keeps direction and correction
    add_row(OP_TICK, 0, 0, 0, 0, 0, 1'b1,
            idle_report(0, 1'b1, 32'h8000_0000, StepsMax));
    // zero distance clears the correction
    add_row(OP_START, 32'd0, 1'b0, 24'd5, 0, 0, 1'b1,
            idle_report(0, 1'b0, 32'h8000_0000, 0));
    // absolute distance wraps to minus one
    add_row(OP_START, 32'h7FFF_FFFF, 1'b1, 0, 0, 0, 1'b1,
            idle_report(1, 1'b1, 32'h7FFF_FFFF, 1));
    // all seven phases one sample each, backward step and final flush
    add_row(OP_START, 32'd7, 1'b0, 24'd1, 24'd1, 31'd1, 1'b0, '0);
    repeat (7) add_row(OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0);
    // reverse move with empty constant and cruise phases skipped
    add_row(OP_START, -32'sd3, 1'b0, 24'd1, 0, 0, 1'b0, '0);
    repeat (4) add_row(OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0);
    // new start abandons a running move, first phase empty
    add_row(OP_START, 32'd100, 1'b0, 24'd3, 24'd2, 31'd2, 1'b0, '0);
    add_row(OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(OP_START, 32'hFFFF_FFFF, 1'b1, 24'd0, 24'd1, 31'd0, 1'b0, '0);
    repeat (2) add_row(OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0);
    // largest field values
    add_row(OP_START, 32'h7FFF_FFFF, 1'b0, 24'hFF_FFFF, 24'hFF_FFFF, 31'h7FFF_FFFF,
            1'b0, '0);
    add_row(OP_TICK, 0, 0, 0, 0, 0, 1'b0, '0);

    // jerk register comes out of reset at its default
    cfg_read(rd);
    if (rd != {1'b0, JERK_RESET}) begin
      $error("jerk_per_sample: expected %0d, got %0d", JERK_RESET, rd);
      mismatches++;
    end

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      d = (row.op == OP_TICK) ? noise_data()
                              : pack_move(row.target, row.absol, row.jerk_cnt,
                                          row.const_cnt, row.cruise_cnt);
      send_item(row.op, d, row.known, row.want);
    end

    // random moves under several jerk settings
    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      case (ph)
        0:       jerk_pick = 31'd1;
        1:       jerk_pick = 31'h7FFF_FFFF;
        2:       jerk_pick = 31'($urandom_range(2, 1000));
        3:       jerk_pick = 31'($urandom_range(1000, 32'h7FFF_FFFF));
        default: jerk_pick = 31'($urandom_range(1, 32'h7FFF_FFFF));
      endcase
      set_jerk(jerk_pick);
      if (ph == 1) begin
        // long jerk phase at full jerk, then abandoned
        send_item(OP_START, pack_move(32'd5000000, 1'b0, 24'd600, 24'd0, 31'd0),
                  1'b0, '0);
        repeat (40) send_tick();
      end
      base = items_sent;
      while (items_sent < base + 90) run_move();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
